FILE: rtl/nts_pkg.sv
// Shared types, constants and lookup functions for the note text square wave player.
// No dependencies; imported by every module of the block.
`default_nettype none

package nts_pkg;

  localparam int unsigned TICKS_PER_MS_DEF = 1000;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;
  localparam int unsigned UNIT_MS_RST      = 150;
  localparam int unsigned MAX24            = 24'hFF_FFFF;
  localparam int unsigned MAX19            = 19'h7_FFFF;

  localparam logic [3:0] REST_CODE  = 4'd14;
  localparam logic [3:0] OTHER_CODE = 4'd15;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_TICK = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } op_kind_t;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_HIGH = 5'b00010,
    MODE_LOW  = 5'b00100,
    MODE_REST = 5'b01000,
    MODE_GAP  = 5'b10000
  } play_mode_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [3:0]  cls;
    logic        digit;
    logic [23:0] total;
  } nts_item_t;

  localparam int unsigned ITEM_W = $bits(nts_item_t);

  function automatic logic [3:0] classify(input logic [7:0] c);
    logic [3:0] code;
    code = OTHER_CODE;
    case (c)
      8'h20: code = REST_CODE;
      8'h43: code = 4'd0;
      8'h44: code = 4'd1;
      8'h45: code = 4'd2;
      8'h46: code = 4'd3;
      8'h47: code = 4'd4;
      8'h41: code = 4'd5;
      8'h42: code = 4'd6;
      8'h63: code = 4'd7;
      8'h64: code = 4'd8;
      8'h65: code = 4'd9;
      8'h66: code = 4'd10;
      8'h67: code = 4'd11;
      8'h61: code = 4'd12;
      8'h62: code = 4'd13;
      default: code = OTHER_CODE;
    endcase
    return code;
  endfunction

  function automatic logic [10:0] half_period_of(input logic [3:0] code);
    logic [10:0] hp;
    hp = 11'd0;
    case (code)
      4'd0:  hp = 11'd1915;
      4'd1:  hp = 11'd1700;
      4'd2:  hp = 11'd1519;
      4'd3:  hp = 11'd1432;
      4'd4:  hp = 11'd1275;
      4'd5:  hp = 11'd1136;
      4'd6:  hp = 11'd1014;
      4'd7:  hp = 11'd956;
      4'd8:  hp = 11'd741;
      4'd9:  hp = 11'd560;
      4'd10: hp = 11'd473;
      4'd11: hp = 11'd351;
      4'd12: hp = 11'd212;
      4'd13: hp = 11'd90;
      default: hp = 11'd0;
    endcase
    return hp;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nts_front.sv
// Front end: decodes incoming requests, scales the unit register to ticks
// and computes item play time. Depends on nts_pkg.
`default_nettype none

module nts_front #(
  parameter int unsigned TICKS_PER_MS = nts_pkg::TICKS_PER_MS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [9:0]        cfg_wdata,
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        symbol,
  output nts_pkg::nts_item_t     item,
  output logic      [18:0]       gap_ticks
);
  import nts_pkg::*;

  localparam int unsigned TW       = $clog2(TICKS_PER_MS + 1);
  localparam int unsigned UW       = 10 + TW;
  localparam int unsigned GW       = 9 + TW;
  localparam logic [TW-1:0] TICKS  = TW'(TICKS_PER_MS);
  localparam int unsigned UNIT_RAW = UNIT_MS_RST * TICKS_PER_MS;
  localparam int unsigned GAP_RAW  = (UNIT_MS_RST / 2) * TICKS_PER_MS;
  localparam logic [23:0] UNIT_RST = (UNIT_RAW > MAX24) ? 24'(MAX24) : 24'(UNIT_RAW);
  localparam logic [18:0] GAP_RST  = (GAP_RAW > MAX19) ? 19'(MAX19) : 19'(GAP_RAW);

  logic [23:0]      unit_ticks_r, unit_ticks_nxt;
  logic [18:0]      gap_ticks_r, gap_ticks_nxt;
  logic [UW-1:0]    unit_prod;
  logic [GW-1:0]    gap_prod;
  logic [31:0]      unit_prod32, gap_prod32;
  logic             is_digit;
  logic [3:0]       len;
  logic [27:0]      tot_prod;

  assign unit_prod   = UW'(cfg_wdata) * UW'(TICKS);
  assign gap_prod    = GW'(cfg_wdata[9:1]) * GW'(TICKS);
  assign unit_prod32 = 32'(unit_prod);
  assign gap_prod32  = 32'(gap_prod);

  always_comb begin
    unit_ticks_nxt = unit_ticks_r;
    gap_ticks_nxt  = gap_ticks_r;
    if (cfg_we) begin
      unit_ticks_nxt = (unit_prod32 > MAX24) ? 24'(MAX24) : unit_prod32[23:0];
      gap_ticks_nxt  = (gap_prod32 > MAX19) ? 19'(MAX19) : gap_prod32[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_RST;
      gap_ticks_r  <= GAP_RST;
    end else begin
      unit_ticks_r <= unit_ticks_nxt;
      gap_ticks_r  <= gap_ticks_nxt;
    end
  end

  always_comb begin
    is_digit   = (op == OP_CHAR) && (symbol inside {[8'h31:8'h39]});
    len        = is_digit ? symbol[3:0] : 4'd1;
    tot_prod   = 28'(len) * 28'(unit_ticks_r);
    item.kind  = op_kind_t'(op);
    item.cls   = classify(symbol);
    item.digit = is_digit;
    item.total = (tot_prod > 28'(MAX24)) ? 24'(MAX24) : tot_prod[23:0];
  end

  assign gap_ticks = gap_ticks_r;

endmodule

`default_nettype wire

FILE: rtl/nts_queue.sv
// Short register queue between the decode front end and the player back end.
// Depends on nts_pkg for default widths only.
`default_nettype none

module nts_queue #(
  parameter int unsigned WIDTH = nts_pkg::ITEM_W,
  parameter int unsigned DEPTH = nts_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  valid,
  output logic      [WIDTH-1:0] rdata
);
  import nts_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nts_back.sv
// Back end: the player state machine, tone and gap counters, and the result register.
// Depends on nts_pkg.
`default_nettype none

module nts_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire nts_pkg::nts_item_t q_item,
  output logic                    q_pop,
  input  wire logic [18:0]        gap_ticks,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [7:0]         out_tdata
);
  import nts_pkg::*;

  play_mode_t  mode_r, mode_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [3:0]  pend_note_r, pend_note_nxt;
  logic [10:0] half_r, half_nxt;
  logic [10:0] hcnt_r, hcnt_nxt;
  logic [23:0] elapsed_r, elapsed_nxt;
  logic [23:0] total_r, total_nxt;
  logic [18:0] gap_r, gap_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        pin_r, ready_r, drop_r;
  logic        drop_nxt;
  logic        start_go, gap_go;
  logic [10:0] hc_inc;
  logic [24:0] el_sum;
  logic [23:0] el_sat;
  logic [18:0] gap_dec;

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  always_comb begin
    mode_nxt      = mode_r;
    pend_v_nxt    = pend_v_r;
    pend_note_nxt = pend_note_r;
    half_nxt      = half_r;
    hcnt_nxt      = hcnt_r;
    elapsed_nxt   = elapsed_r;
    total_nxt     = total_r;
    gap_nxt       = gap_r;
    drop_nxt      = 1'b0;
    start_go      = 1'b0;
    gap_go        = 1'b0;
    hc_inc        = hcnt_r + 11'd1;
    el_sum        = {1'b0, elapsed_r} + {13'd0, half_r, 1'b0};
    el_sat        = el_sum[24] ? 24'(MAX24) : el_sum[23:0];
    gap_dec       = (gap_r != '0) ? gap_r - 19'd1 : '0;
    if (q_pop) begin
      case (q_item.kind)
        OP_CHAR: begin
          if (mode_r != MODE_IDLE) begin
            drop_nxt = 1'b1;
          end else if (pend_v_r) begin
            start_go = 1'b1;
            if (q_item.digit || q_item.cls == OTHER_CODE) begin
              pend_v_nxt = 1'b0;
            end else begin
              pend_note_nxt = q_item.cls;
            end
          end else if (q_item.cls != OTHER_CODE) begin
            pend_note_nxt = q_item.cls;
            pend_v_nxt    = 1'b1;
          end
        end
        OP_END: begin
          if (mode_r != MODE_IDLE) begin
            drop_nxt = 1'b1;
          end else if (pend_v_r) begin
            start_go   = 1'b1;
            pend_v_nxt = 1'b0;
          end
        end
        OP_TICK: begin
          case (mode_r)
            MODE_HIGH: begin
              if (hc_inc >= half_r) begin
                hcnt_nxt = '0;
                mode_nxt = MODE_LOW;
              end else begin
                hcnt_nxt = hc_inc;
              end
            end
            MODE_LOW: begin
              if (hc_inc >= half_r) begin
                hcnt_nxt    = '0;
                elapsed_nxt = el_sat;
                if (el_sat < total_r) begin
                  mode_nxt = MODE_HIGH;
                end else begin
                  gap_go = 1'b1;
                end
              end else begin
                hcnt_nxt = hc_inc;
              end
            end
            MODE_REST: begin
              elapsed_nxt = (elapsed_r == 24'(MAX24)) ? elapsed_r : elapsed_r + 24'd1;
              if (elapsed_nxt >= total_r) begin
                gap_go = 1'b1;
              end
            end
            MODE_GAP: begin
              gap_nxt = gap_dec;
              if (gap_dec == '0) begin
                mode_nxt = MODE_IDLE;
              end
            end
            default: begin
              mode_nxt = MODE_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    if (start_go) begin
      total_nxt   = q_item.total;
      elapsed_nxt = '0;
      hcnt_nxt    = '0;
      if (q_item.total == '0) begin
        gap_go = 1'b1;
      end else if (pend_note_r != REST_CODE) begin
        half_nxt = half_period_of(pend_note_r);
        mode_nxt = MODE_HIGH;
      end else begin
        mode_nxt = MODE_REST;
      end
    end
    if (gap_go) begin
      gap_nxt  = gap_ticks;
      mode_nxt = (gap_ticks == '0) ? MODE_IDLE : MODE_GAP;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_note_r <= pend_note_nxt;
    half_r      <= half_nxt;
    hcnt_r      <= hcnt_nxt;
    elapsed_r   <= elapsed_nxt;
    total_r     <= total_nxt;
    gap_r       <= gap_nxt;
    if (q_pop) begin
      pin_r   <= (mode_nxt == MODE_HIGH);
      ready_r <= (mode_nxt == MODE_IDLE);
      drop_r  <= drop_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, drop_r, ready_r, pin_r};

  a_gap_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_GAP) |-> (gap_r != '0))
    else $error("gap mode with empty gap counter");

  a_half_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HIGH || mode_r == MODE_LOW) |-> (hcnt_r < half_r))
    else $error("half-cycle counter past half period");

  a_drop_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.kind == OP_CHAR && mode_r != MODE_IDLE)
      |=> (mode_r == $past(mode_r) && pend_v_r == $past(pend_v_r)))
    else $error("dropped character changed player state");

  a_pin_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(pin_r && ready_r))
    else $error("pin high while reporting idle");

  a_busy_no_start : assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && mode_r == MODE_GAP && q_item.kind != OP_TICK) |=> (mode_r == MODE_GAP))
    else $error("non-tick request left gap mode");

endmodule

`default_nettype wire

FILE: rtl/note_text_square_wave_player.sv
// Top level of the note text square wave player: front end, queue and back end.
// Depends on nts_pkg, nts_front, nts_queue and nts_back.
//
// Usage:
//   in_*  : request stream. in_tuser[1:0] is op (0 character, 1 one-tick time step,
//           2 end of string); in_tdata[7:0] is the ASCII symbol.
//   out_* : one result per request. out_tdata bit 0 pin_level, bit 1 ready_res,
//           bit 2 dropped, upper bits zero.
//   cfg_* : cfg_we writes unit_ms from cfg_wdata; write only while no request is
//           in flight. It takes effect for requests accepted after the write edge.
// Order: an accepted request is written into the queue, and its result is registered when the back end pops it.
// Throughput: one request per cycle while out_tready is high; the back end updates its state
//   once per request and the queue holds QUEUE_DEPTH requests.
// Reset: unit_ms returns to 150, the player is idle with nothing pending and the
//   output register is empty.
// Stall: while out_tready is low the result register holds, the queue fills, and
//   in_tready drops once QUEUE_DEPTH requests are waiting.
`default_nettype none

module note_text_square_wave_player #(
  parameter int unsigned TICKS_PER_MS = nts_pkg::TICKS_PER_MS_DEF,
  parameter int unsigned QUEUE_DEPTH  = nts_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] symbol
  input  wire logic [1:0] in_tuser,   // [1:0] op
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [0] pin_level, [1] ready_res, [2] dropped
  input  wire logic       cfg_we,
  input  wire logic [9:0] cfg_wdata   // [9:0] unit_ms
);
  import nts_pkg::*;

  nts_item_t   dec_item;
  nts_item_t   q_item;
  logic [18:0] gap_ticks;
  logic        q_full, q_valid, q_pop, q_push;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  nts_front #(
    .TICKS_PER_MS(TICKS_PER_MS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op        (in_tuser),
    .symbol    (in_tdata),
    .item      (dec_item),
    .gap_ticks (gap_ticks)
  );

  nts_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (dec_item),
    .pop   (q_pop),
    .full  (q_full),
    .valid (q_valid),
    .rdata (q_item)
  );

  nts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .gap_ticks  (gap_ticks),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
